### rtl/fifo_ready_queue_scheduler_top_defines.svh
// Assertion macros shared by the scheduler modules.
`ifndef FIFO_READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define FIFO_READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FRQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frqs assertion failed");

// Next-cycle implication, checked out of reset.
`define FRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frqs assertion failed");

`endif

### rtl/frqs_pkg.sv
package frqs_pkg;

    localparam int NUM_THREADS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int THREAD_ID_W     = 5;
    localparam int SCHED_W         = 4;

    typedef enum logic [1:0] {
        REQ_READY   = 2'd0,
        REQ_PREEMPT = 2'd1,
        REQ_WAIT    = 2'd2,
        REQ_SCHED   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_BAD_ID = 2'd1,
        RES_EMPTY  = 2'd2,
        RES_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_WAITING = 2'd3
    } t_tstate;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

### rtl/frqs_cell.sv
module frqs_cell (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic                             i_shift,
    input  logic [frqs_pkg::THREAD_ID_W-1:0] i_load_id,
    input  logic [frqs_pkg::THREAD_ID_W-1:0] i_next_id,
    output logic [frqs_pkg::THREAD_ID_W-1:0] o_id
);

    logic [frqs_pkg::THREAD_ID_W-1:0] r_id;
    logic [frqs_pkg::THREAD_ID_W-1:0] n_id;

    // A cell takes a new id at the tail, the id of the cell behind it, or holds its own.
    always_comb begin
        if (i_load) begin
            n_id = i_load_id;
        end else if (i_shift) begin
            n_id = i_next_id;
        end else begin
            n_id = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id = r_id;

endmodule

### rtl/frqs_queue.sv
`include "fifo_ready_queue_scheduler_top_defines.svh"

module frqs_queue #(
    parameter int QUEUE_DEPTH = frqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  frqs_pkg::t_q_ctrl                i_ctrl,
    input  logic [frqs_pkg::THREAD_ID_W-1:0] i_push_id,
    output logic [frqs_pkg::THREAD_ID_W-1:0] o_head_id,
    output frqs_pkg::t_q_stat                o_stat
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic [frqs_pkg::THREAD_ID_W-1:0] w_id [QUEUE_DEPTH];

    // The head sits in cell zero; a pop moves every entry one cell forward.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [frqs_pkg::THREAD_ID_W-1:0] w_next;
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_id[i+1];
        end
        frqs_cell u_cell (
            .i_clk     (i_clk),
            .i_load    (i_ctrl.push && (r_count == CNT_W'(i))),
            .i_shift   (i_ctrl.pop),
            .i_load_id (i_push_id),
            .i_next_id (w_next),
            .o_id      (w_id[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head_id    = w_id[0];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));

    `FRQS_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `FRQS_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_ctrl.push, !o_stat.full && !i_ctrl.pop)
    `FRQS_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, i_ctrl.pop, r_count + 1'b1 == $past(r_count))

endmodule

### rtl/fifo_ready_queue_scheduler_top.sv
// Hardware thread scheduler with a FIFO ready queue.
// Input channel (i_in_valid / o_in_ready) carries one request per beat:
// i_req_type selects ready, preempted, waiting or schedule-next, and
// i_thread_id names the thread for the first three. Output channel
// (o_out_valid / i_out_ready) returns exactly one result beat per request:
// o_status, o_sched_thread and o_new_state.
// A request is resolved in the cycle it is accepted and its result is
// registered; up to one request per cycle is taken while results are
// drained. The rate is set by the single output register: o_in_ready is
// high when that register is empty or being read.
// The ready queue is a row of cells; a pop moves every entry one cell
// towards the head, a push loads the first free cell.
// A synchronous reset (i_rst_n low) marks every thread unused and empties
// the queue; queue contents are not cleared and need no clearing pass.
// If the receiver holds i_out_ready low, the result stays on the outputs
// and no new request is accepted until it is taken.
`include "fifo_ready_queue_scheduler_top_defines.svh"

module fifo_ready_queue_scheduler_top #(
    parameter int NUM_THREADS = frqs_pkg::NUM_THREADS_DEF,
    parameter int QUEUE_DEPTH = frqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_req_type,
    input  logic [frqs_pkg::THREAD_ID_W-1:0] i_thread_id,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic [frqs_pkg::SCHED_W-1:0]     o_sched_thread,
    output logic [1:0]                       o_new_state
);

    localparam int IDX_W = $clog2(NUM_THREADS);

    frqs_pkg::t_tstate r_tstate [NUM_THREADS];

    logic                             r_out_valid;
    frqs_pkg::t_status                r_status;
    frqs_pkg::t_status                n_status;
    logic [frqs_pkg::SCHED_W-1:0]     r_sched;
    logic [frqs_pkg::SCHED_W-1:0]     n_sched;
    frqs_pkg::t_tstate                r_state;
    frqs_pkg::t_tstate                n_state;

    logic                             w_acc;
    frqs_pkg::t_req                   w_req;
    logic                             w_bad_id;
    logic [IDX_W-1:0]                 w_idx;
    logic [IDX_W-1:0]                 w_head_idx;
    logic                             w_we;
    logic [IDX_W-1:0]                 w_wr_idx;
    frqs_pkg::t_tstate                w_wr_state;
    frqs_pkg::t_q_ctrl                w_qctrl;
    frqs_pkg::t_q_stat                w_qstat;
    logic [frqs_pkg::THREAD_ID_W-1:0] w_head_id;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_req      = frqs_pkg::t_req'(i_req_type);
    assign w_bad_id   = int'(i_thread_id) >= NUM_THREADS;
    assign w_idx      = IDX_W'(i_thread_id);
    assign w_head_idx = IDX_W'(w_head_id);

    frqs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_qctrl),
        .i_push_id (i_thread_id),
        .o_head_id (w_head_id),
        .o_stat    (w_qstat)
    );

    always_comb begin
        n_status     = frqs_pkg::RES_OK;
        n_sched      = '0;
        n_state      = frqs_pkg::ST_UNUSED;
        w_we         = 1'b0;
        w_wr_idx     = w_idx;
        w_wr_state   = frqs_pkg::ST_READY;
        w_qctrl.push = 1'b0;
        w_qctrl.pop  = 1'b0;
        case (w_req)
            frqs_pkg::REQ_SCHED: begin
                if (w_qstat.empty) begin
                    n_status = frqs_pkg::RES_EMPTY;
                end else begin
                    w_qctrl.pop = w_acc;
                    w_we        = w_acc;
                    w_wr_idx    = w_head_idx;
                    w_wr_state  = frqs_pkg::ST_RUNNING;
                    n_sched     = w_head_id[frqs_pkg::SCHED_W-1:0];
                    n_state     = frqs_pkg::ST_RUNNING;
                end
            end
            frqs_pkg::REQ_WAIT: begin
                if (w_bad_id) begin
                    n_status = frqs_pkg::RES_BAD_ID;
                end else begin
                    w_we       = w_acc;
                    w_wr_state = frqs_pkg::ST_WAITING;
                    n_state    = frqs_pkg::ST_WAITING;
                end
            end
            frqs_pkg::REQ_READY, frqs_pkg::REQ_PREEMPT: begin
                if (w_bad_id) begin
                    n_status = frqs_pkg::RES_BAD_ID;
                end else if (w_qstat.full) begin
                    // The append is dropped and the thread keeps its state.
                    n_status = frqs_pkg::RES_FULL;
                    n_state  = r_tstate[w_idx];
                end else begin
                    w_qctrl.push = w_acc;
                    w_we         = w_acc;
                    n_state      = frqs_pkg::ST_READY;
                end
            end
            default: begin
                n_status = frqs_pkg::RES_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                r_tstate[i] <= frqs_pkg::ST_UNUSED;
            end
        end else if (w_we) begin
            r_tstate[w_wr_idx] <= w_wr_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_sched  <= n_sched;
            r_state  <= n_state;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_sched_thread = r_sched;
    assign o_new_state    = r_state;

    `FRQS_ASSERT_NEXT(a_sched_running, i_clk, i_rst_n,
        w_acc && (w_req == frqs_pkg::REQ_SCHED) && !w_qstat.empty,
        r_tstate[$past(w_head_idx)] == frqs_pkg::ST_RUNNING)
    `FRQS_ASSERT_NEXT(a_wait_marks, i_clk, i_rst_n,
        w_acc && (w_req == frqs_pkg::REQ_WAIT) && !w_bad_id,
        r_tstate[$past(w_idx)] == frqs_pkg::ST_WAITING)
    `FRQS_ASSERT_NOW(a_bad_id_quiet, i_clk, i_rst_n,
        r_out_valid && (r_status == frqs_pkg::RES_BAD_ID),
        (r_sched == '0) && (r_state == frqs_pkg::ST_UNUSED))

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        frqs_pkg::t_status            status;
        logic [frqs_pkg::SCHED_W-1:0] sched_thread;
        frqs_pkg::t_tstate            new_state;
    } t_sched_result;

    typedef struct packed {
        frqs_pkg::t_req                   req;
        logic [frqs_pkg::THREAD_ID_W-1:0] tid;
        logic                             known;
        t_sched_result                    res;
    } t_dir_row;

    localparam int NUM_DIR    = 22;
    localparam int NUM_RANDOM = 1100;
    localparam int PHASE_LEN  = 64;
    localparam int LONG_HOLD  = 80;
    localparam int HOLD_AT    = 300;

    // Rows marked known carry the result as typed; the rest take the predictor's.
    localparam t_dir_row DIR_TABLE [NUM_DIR] = '{
        '{frqs_pkg::REQ_SCHED, 5'd0, 1'b1, '{frqs_pkg::RES_EMPTY, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_WAIT, 5'd31, 1'b1, '{frqs_pkg::RES_BAD_ID, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_READY, 5'd16, 1'b1, '{frqs_pkg::RES_BAD_ID, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_PREEMPT, 5'd31, 1'b1,
          '{frqs_pkg::RES_BAD_ID, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_READY, 5'd0, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_READY}},
        '{frqs_pkg::REQ_READY, 5'd15, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_READY}},
        '{frqs_pkg::REQ_PREEMPT, 5'd7, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_READY}},
        '{frqs_pkg::REQ_WAIT, 5'd15, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_WAITING}},
        '{frqs_pkg::REQ_SCHED, 5'd0, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_RUNNING}},
        '{frqs_pkg::REQ_SCHED, 5'd31, 1'b1, '{frqs_pkg::RES_OK, 4'd15, frqs_pkg::ST_RUNNING}},
        '{frqs_pkg::REQ_SCHED, 5'd10, 1'b1, '{frqs_pkg::RES_OK, 4'd7, frqs_pkg::ST_RUNNING}},
        '{frqs_pkg::REQ_SCHED, 5'd0, 1'b1, '{frqs_pkg::RES_EMPTY, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_WAIT, 5'd0, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_WAITING}},
        '{frqs_pkg::REQ_WAIT, 5'd9, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_WAITING}},
        '{frqs_pkg::REQ_PREEMPT, 5'd0, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_READY}},
        '{frqs_pkg::REQ_READY, 5'd0, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_READY}},
        '{frqs_pkg::REQ_SCHED, 5'd0, 1'b1, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_RUNNING}},
        '{frqs_pkg::REQ_READY, 5'd10, 1'b0, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_PREEMPT, 5'd21, 1'b0, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_SCHED, 5'd0, 1'b0, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_SCHED, 5'd0, 1'b0, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_UNUSED}},
        '{frqs_pkg::REQ_SCHED, 5'd0, 1'b0, '{frqs_pkg::RES_OK, 4'd0, frqs_pkg::ST_UNUSED}}
    };

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_ready;
    logic [1:0]                       i_req_type  = 2'd0;
    logic [frqs_pkg::THREAD_ID_W-1:0] i_thread_id = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [1:0]                       o_status;
    logic [frqs_pkg::SCHED_W-1:0]     o_sched_thread;
    logic [1:0]                       o_new_state;

    frqs_pkg::t_tstate            thr_state [frqs_pkg::NUM_THREADS_DEF];
    logic [frqs_pkg::SCHED_W-1:0] ready_fifo [$];
    t_sched_result                pending_results [$];
    int                           err_count   = 0;
    int                           beats_taken = 0;
    bit                           no_gaps     = 1'b0;

    fifo_ready_queue_scheduler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_thread_id    (i_thread_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_sched_thread (o_sched_thread),
        .o_new_state    (o_new_state)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_sched_result predict_outcome(input frqs_pkg::t_req req,
                                                      input logic [frqs_pkg::THREAD_ID_W-1:0] tid);
        t_sched_result r;
        r = '{frqs_pkg::RES_OK, '0, frqs_pkg::ST_UNUSED};
        if (req == frqs_pkg::REQ_SCHED) begin
            if (ready_fifo.size() == 0) begin
                r.status = frqs_pkg::RES_EMPTY;
            end else begin
                r.sched_thread = ready_fifo.pop_front();
                thr_state[r.sched_thread] = frqs_pkg::ST_RUNNING;
                r.new_state = frqs_pkg::ST_RUNNING;
            end
        end else if (tid >= frqs_pkg::NUM_THREADS_DEF) begin
            r.status = frqs_pkg::RES_BAD_ID;
        end else if (req == frqs_pkg::REQ_WAIT) begin
            // A queued entry of a thread put to waiting stays in the queue.
            thr_state[tid] = frqs_pkg::ST_WAITING;
            r.new_state = frqs_pkg::ST_WAITING;
        end else if (ready_fifo.size() >= frqs_pkg::QUEUE_DEPTH_DEF) begin
            r.status = frqs_pkg::RES_FULL;
            r.new_state = thr_state[tid];
        end else begin
            thr_state[tid] = frqs_pkg::ST_READY;
            ready_fifo.push_back(tid[frqs_pkg::SCHED_W-1:0]);
            r.new_state = frqs_pkg::ST_READY;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic offer_req(input frqs_pkg::t_req req,
                             input logic [frqs_pkg::THREAD_ID_W-1:0] tid,
                             input logic known, input t_sched_result typed);
        int            gap;
        t_sched_result predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_thread_id <= tid;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = predict_outcome(req, tid);
        pending_results.push_back(known ? typed : predicted);
        @(negedge i_clk);
    endtask

    initial begin
        frqs_pkg::t_req                   req;
        logic [frqs_pkg::THREAD_ID_W-1:0] tid;
        int                               pick;
        int                               mix_mode;
        for (int k = 0; k < frqs_pkg::NUM_THREADS_DEF; k++) thr_state[k] = frqs_pkg::ST_UNUSED;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < NUM_DIR; k++) begin
            offer_req(DIR_TABLE[k].req, DIR_TABLE[k].tid, DIR_TABLE[k].known,
                      DIR_TABLE[k].res);
        end

        // Phases lean towards filling, draining or an even mix, so that the
        // queue runs both full and empty many times over.
        mix_mode = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                mix_mode = (n == 0) ? 0 : $urandom_range(0, 2);
                no_gaps  = ($urandom_range(0, 3) == 0);
            end
            if (n == NUM_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (pending_results.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if ((mix_mode == 0 && pick < 15) || (mix_mode == 1 && pick < 75) ||
                (mix_mode == 2 && pick < 35)) begin
                req = frqs_pkg::REQ_SCHED;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20)      req = frqs_pkg::REQ_WAIT;
                else if (pick < 60) req = frqs_pkg::REQ_PREEMPT;
                else                req = frqs_pkg::REQ_READY;
            end
            if ($urandom_range(0, 99) < 85) begin
                tid = frqs_pkg::THREAD_ID_W'($urandom_range(0, 15));
            end else begin
                tid = frqs_pkg::THREAD_ID_W'($urandom_range(16, 31));
            end
            offer_req(req, tid, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        int            stall;
        t_sched_result want;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            // One long hold-off lets the output register back up into the input.
            if (beats_taken == HOLD_AT) stall = LONG_HOLD;
            else                        stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            beats_taken++;
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("tb: unexpected result beat: status %0d thread %0d state %0d",
                             o_status, o_sched_thread, o_new_state);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_sched_thread !== want.sched_thread ||
                    o_new_state !== want.new_state) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("tb: mismatch on beat %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 beats_taken, want.status, want.sched_thread,
                                 want.new_state, o_status, o_sched_thread, o_new_state);
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
